// ----- rtl/core/aeap_pkg.sv -----
// ----------------------------------------------------------------------------
// aeap_pkg
// Shared types and constants for the terminal escape attribute parser.
// ----------------------------------------------------------------------------
package aeap_pkg;

	// parse modes
	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_ESC  = 2'd1,
		MODE_CSI  = 2'd2,
		MODE_OSC  = 2'd3
	} mode_t;

	// result kinds
	localparam logic KIND_GLYPH = 1'b0;
	localparam logic KIND_EOL   = 1'b1;

	// byte codes
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_LB  = 8'h5B;
	localparam logic [7:0] CH_RB  = 8'h5D;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_QM  = 8'h3F;
	localparam logic [7:0] CH_0   = 8'h30;
	localparam logic [7:0] CH_9   = 8'h39;
	localparam logic [7:0] FIN_M  = 8'h6D;
	localparam logic [7:0] FIN_A  = 8'h41;
	localparam logic [7:0] FIN_B  = 8'h42;
	localparam logic [7:0] FIN_C  = 8'h43;
	localparam logic [7:0] FIN_D  = 8'h44;
	localparam logic [7:0] FIN_H  = 8'h48;
	localparam logic [7:0] FIN_F  = 8'h66;

	localparam int MAX_RESULTS = 8;

	// one result as it leaves the block
	typedef struct packed {
		logic        kind;
		logic [7:0]  glyph;
		logic [4:0]  fg;
		logic [4:0]  bg;
		logic [3:0]  attr;
		logic [11:0] row;
		logic [11:0] col;
		logic        last;
	} result_t;

	// SGR colour decode: code minus base, plus an index offset
	function automatic logic [4:0] sgr_colour(input logic [15:0] c, input logic [15:0] b,
		input logic [4:0] off);
		logic [15:0] d;
		d = c - b;
		return 5'(d[3:0]) + off;
	endfunction

endpackage

// ----- rtl/core/ansi_escape_attribute_parser.sv -----
// ----------------------------------------------------------------------------
// ansi_escape_attribute_parser
// Terminal byte parser: text, ESC, CSI and OSC modes, SGR attributes,
// cursor moves, glyph and line-end results.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | to block  | in_valid/stall   | byte_in
// out     | from block| out_valid/stall  | kind glyph fg_index bg_index attrs row col last
//
// A control or escape byte is accepted, then decoded and applied in S_DEC.
// A printable byte goes on from S_DEC to S_EMIT; a tab emits one space per column to the next stop.
// A CSI digit or '?' passes S_DEC, S_RDW and S_DIG (parameter RAM read, then read-modify-write).
// A CSI final walks the parameter RAM, reading each field in S_SGRR and applying it in S_SGRA.
// Results leave one per cycle, unless the output stalls, from an output register;
// a tab gives up to 8. Output stalls hold the sequencer; reset clears all control
// state, the parameter RAM needs no clearing since a field is written when opened.
// ----------------------------------------------------------------------------
module ansi_escape_attribute_parser #(
	parameter int MAX_PARAMS  = 16,
	parameter int ROW_LIMIT   = 4095,
	parameter int COL_LIMIT   = 4095,
	parameter int PARAM_LIMIT = 65535,
	parameter int TAB_WIDTH   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  glyph,
	output logic [4:0]  fg_index,
	output logic [4:0]  bg_index,
	output logic        bold,
	output logic        italic,
	output logic        underline,
	output logic        inverse,
	output logic [11:0] row,
	output logic [11:0] col,
	output logic        last
);
	import aeap_pkg::*;

	localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int CW = $clog2(MAX_PARAMS + 1);
	localparam int TW = $clog2(TAB_WIDTH + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DEC   = 7'b0000010,
		S_RDW   = 7'b0000100,
		S_DIG   = 7'b0001000,
		S_SGRR  = 7'b0010000,
		S_SGRA  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t      state_q;
	mode_t       mode_q;
	logic [7:0]  byte_q;
	logic [CW-1:0] pcount_q;
	logic        drop_q;
	logic [4:0]  fg_q, bg_q;
	logic [3:0]  attr_q;
	logic [15:0] crow_q, ccol_q;
	logic [AW-1:0] idx_q;
	logic [TW-1:0] spaces_q;
	logic [3:0]  nemit_q;
	logic [15:0] p0v_q, p1v_q;
	logic [1:0]  p0f_q, p1f_q;
	result_t     res_q;
	logic        ovalid_q;

	// parameter store: {flags, value}
	logic          ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [17:0]   ram_wd, ram_rd;

	aeap_ram #(.WIDTH(18), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic is_digit, is_param;
	logic [15:0] dig_sum;
	logic [19:0] dig_mul;
	logic out_free;
	logic res_load;
	assign is_digit = byte_q >= CH_0 && byte_q <= CH_9;
	assign is_param = is_digit || byte_q == CH_SEMI || byte_q == CH_QM;
	assign dig_mul  = 20'(ram_rd[15:0]) * 20'd10 + 20'(byte_q - CH_0);
	assign dig_sum  = (dig_mul > 20'(PARAM_LIMIT)) ? 16'(PARAM_LIMIT) : dig_mul[15:0];
	assign out_free = !ovalid_q || !out_stall;
	// a new result enters the output register
	assign res_load = out_free && ((state_q == S_DEC && mode_q == MODE_TEXT && byte_q == CH_LF)
		|| (state_q == S_EMIT && spaces_q != '0 && nemit_q < 4'(MAX_RESULTS)));

	assign in_stall = state_q != S_IDLE;

	// field helpers for cursor moves
	logic ok0, ok1;
	logic [15:0] mcount, pos_r, pos_c;
	assign ok0 = pcount_q >= CW'(1) && p0f_q == 2'b01;
	assign ok1 = pcount_q >= CW'(2) && p1f_q == 2'b01;
	assign mcount = (ok0 && p0v_q != 16'd0) ? p0v_q : 16'd1;
	assign pos_r = (ok0 && p0v_q != 16'd0) ?
		((p0v_q - 16'd1 > 16'(ROW_LIMIT)) ? 16'(ROW_LIMIT) : p0v_q - 16'd1) : 16'd0;
	assign pos_c = (ok1 && p1v_q != 16'd0) ?
		((p1v_q - 16'd1 > 16'(COL_LIMIT)) ? 16'(COL_LIMIT) : p1v_q - 16'd1) : 16'd0;

	// RAM port control
	always_comb begin
		ram_we = 1'b0;
		ram_wa = '0;
		ram_wd = '0;
		ram_ra = idx_q;
		if (state_q == S_DEC) begin
			ram_ra = AW'(pcount_q - CW'(1));
			if (mode_q == MODE_ESC && byte_q == CH_LB) begin
				ram_we = 1'b1;
			end else if (mode_q == MODE_CSI && byte_q == CH_SEMI && !drop_q
				&& pcount_q < CW'(MAX_PARAMS)) begin
				ram_we = 1'b1;
				ram_wa = AW'(pcount_q);
			end
		end else if (state_q == S_RDW) begin
			ram_ra = AW'(pcount_q - CW'(1));
		end else if (state_q == S_DIG) begin
			ram_we = 1'b1;
			ram_wa = AW'(pcount_q - CW'(1));
			if (byte_q == CH_QM) ram_wd = {ram_rd[17] | 1'b1, ram_rd[16], ram_rd[15:0]};
			else ram_wd = {ram_rd[17], 1'b1, dig_sum};
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (res_load) ovalid_q <= 1'b1;
		else if (!out_stall) ovalid_q <= 1'b0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			mode_q   <= MODE_TEXT;
			pcount_q <= '0;
			drop_q   <= 1'b0;
			fg_q     <= '0;
			bg_q     <= '0;
			attr_q   <= '0;
			crow_q   <= '0;
			ccol_q   <= '0;
			idx_q    <= '0;
			spaces_q <= '0;
			nemit_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q  <= byte_in;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					case (mode_q)
						MODE_TEXT: begin
							// glyphs go on to emit, a line end waits for the output
							if (byte_q == CH_TAB || byte_q >= CH_SP) state_q <= S_EMIT;
							else if (byte_q != CH_LF || out_free) state_q <= S_IDLE;
							if (byte_q == CH_ESC) mode_q <= MODE_ESC;
							else if (byte_q == CH_LF) begin
								if (out_free) begin
									res_q <= '{kind: KIND_EOL, glyph: CH_LF, fg: '0, bg: '0,
										attr: '0, row: crow_q[11:0], col: ccol_q[11:0], last: 1'b1};
									if (crow_q < 16'(ROW_LIMIT)) crow_q <= crow_q + 16'd1;
									ccol_q <= '0;
								end
							end else if (byte_q == CH_CR) ccol_q <= '0;
							else if (byte_q == CH_BS) begin
								if (ccol_q != 16'd0) ccol_q <= ccol_q - 16'd1;
							end else if (byte_q == CH_TAB) begin
								spaces_q <= TW'(TAB_WIDTH) - TW'(ccol_q % TAB_WIDTH);
								nemit_q  <= '0;
								byte_q   <= CH_SP;
							end else if (byte_q >= CH_SP) begin
								spaces_q <= TW'(1);
								nemit_q  <= '0;
							end
						end
						MODE_ESC: begin
							state_q <= S_IDLE;
							if (byte_q == CH_LB) begin
								mode_q   <= MODE_CSI;
								pcount_q <= CW'(1);
								drop_q   <= 1'b0;
							end else if (byte_q == CH_RB) mode_q <= MODE_OSC;
							else mode_q <= MODE_TEXT;
						end
						MODE_CSI: begin
							state_q <= !is_param ? S_SGRR :
								(!drop_q && byte_q != CH_SEMI) ? S_RDW : S_IDLE;
							if (is_param) begin
								if (!drop_q && byte_q == CH_SEMI) begin
									if (pcount_q < CW'(MAX_PARAMS)) pcount_q <= pcount_q + CW'(1);
									else drop_q <= 1'b1;
								end
							end else begin
								mode_q  <= MODE_TEXT;
								idx_q   <= '0;
							end
						end
						default: begin
							state_q <= S_IDLE;
							if (byte_q == CH_BEL || byte_q == CH_ESC) mode_q <= MODE_TEXT;
						end
					endcase
				end
				S_RDW: state_q <= S_DIG;
				S_DIG: state_q <= S_IDLE;
				// walk fields: read issued with idx_q, applied next cycle
				S_SGRR: state_q <= S_SGRA;
				S_SGRA: begin
					if (idx_q == AW'(0)) begin p0v_q <= ram_rd[15:0]; p0f_q <= ram_rd[17:16]; end
					if (idx_q == AW'(1)) begin p1v_q <= ram_rd[15:0]; p1f_q <= ram_rd[17:16]; end
					if (byte_q == FIN_M) begin
						if (pcount_q == CW'(1) && ram_rd[17:16] == 2'b00) begin
							fg_q <= '0; bg_q <= '0; attr_q <= '0;
						end else if (ram_rd[17:16] == 2'b01) begin
							logic [15:0] c;
							c = ram_rd[15:0];
							if (c == 16'd0) begin fg_q <= '0; bg_q <= '0; attr_q <= '0; end
							else if (c == 16'd1) attr_q[0] <= 1'b1;
							else if (c == 16'd3) attr_q[1] <= 1'b1;
							else if (c == 16'd4) attr_q[2] <= 1'b1;
							else if (c == 16'd7) attr_q[3] <= 1'b1;
							else if (c == 16'd22) attr_q[0] <= 1'b0;
							else if (c == 16'd23) attr_q[1] <= 1'b0;
							else if (c == 16'd24) attr_q[2] <= 1'b0;
							else if (c == 16'd27) attr_q[3] <= 1'b0;
							else if (c >= 16'd30 && c <= 16'd37)
								fg_q <= sgr_colour(c, 16'd30, attr_q[0] ? 5'd9 : 5'd1);
							else if (c == 16'd39) fg_q <= '0;
							else if (c >= 16'd40 && c <= 16'd47) bg_q <= sgr_colour(c, 16'd40, 5'd1);
							else if (c == 16'd49) bg_q <= '0;
							else if (c >= 16'd90 && c <= 16'd97) fg_q <= sgr_colour(c, 16'd90, 5'd9);
							else if (c >= 16'd100 && c <= 16'd107)
								bg_q <= sgr_colour(c, 16'd100, 5'd9);
						end
					end
					if (CW'(idx_q) + CW'(1) < pcount_q && idx_q != AW'(MAX_PARAMS - 1)
						&& (byte_q == FIN_M || idx_q == AW'(0))) begin
						idx_q   <= idx_q + AW'(1);
						state_q <= S_SGRR;
					end else begin
						state_q <= S_EMIT;
						spaces_q <= '0;
						nemit_q  <= '0;
						idx_q    <= '0;
						if (CW'(idx_q) + CW'(1) >= pcount_q || idx_q != AW'(1)) begin
							if (idx_q == AW'(0)) p1f_q <= 2'b00;
						end
					end
				end
				S_EMIT: begin
					// cursor moves are applied here once the fields are loaded
					if (spaces_q == '0) begin
						state_q <= S_IDLE;
						if (mode_q == MODE_TEXT && byte_q != CH_SP && (byte_q == FIN_A ||
							byte_q == FIN_B || byte_q == FIN_C || byte_q == FIN_D ||
							byte_q == FIN_H || byte_q == FIN_F) && nemit_q == '0) begin
							if (byte_q == FIN_A)
								crow_q <= (mcount >= crow_q) ? 16'd0 : crow_q - mcount;
							else if (byte_q == FIN_B)
								crow_q <= (mcount >= 16'(ROW_LIMIT) - crow_q) ?
									16'(ROW_LIMIT) : crow_q + mcount;
							else if (byte_q == FIN_C)
								ccol_q <= (mcount >= 16'(COL_LIMIT) - ccol_q) ?
									16'(COL_LIMIT) : ccol_q + mcount;
							else if (byte_q == FIN_D)
								ccol_q <= (mcount >= ccol_q) ? 16'd0 : ccol_q - mcount;
							else begin
								crow_q <= pos_r;
								ccol_q <= pos_c;
							end
						end
					end else if (out_free) begin
						if (nemit_q < 4'(MAX_RESULTS)) begin
							res_q <= '{kind: KIND_GLYPH, glyph: byte_q, fg: fg_q, bg: bg_q,
								attr: attr_q, row: crow_q[11:0], col: ccol_q[11:0],
								last: spaces_q == TW'(1) || nemit_q == 4'(MAX_RESULTS - 1)};
						end
						if (ccol_q < 16'(COL_LIMIT)) ccol_q <= ccol_q + 16'd1;
						spaces_q <= spaces_q - TW'(1);
						nemit_q  <= (nemit_q < 4'(MAX_RESULTS)) ? nemit_q + 4'd1 : nemit_q;
						if (spaces_q == TW'(1)) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign kind      = res_q.kind;
	assign glyph     = res_q.glyph;
	assign fg_index  = res_q.fg;
	assign bg_index  = res_q.bg;
	assign bold      = res_q.attr[0];
	assign italic    = res_q.attr[1];
	assign underline = res_q.attr[2];
	assign inverse   = res_q.attr[3];
	assign row       = res_q.row;
	assign col       = res_q.col;
	assign last      = res_q.last;
endmodule

// ----- rtl/core/aeap_ram.sv -----
// ----------------------------------------------------------------------------
// aeap_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module aeap_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/core/aeap_checker.sv -----
// ----------------------------------------------------------------------------
// aeap_checker
// Port-level checks for the parser, bound to the top level.
// ----------------------------------------------------------------------------
module aeap_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       kind,
	input logic [4:0] fg_index,
	input logic [7:0] glyph
);
	// a held result keeps its glyph
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(glyph)) else $error("result changed");
	// no new request straight after one is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("accepted back to back");
	// line end carries no attributes
	a_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> fg_index == 5'd0 && glyph == 8'h0A) else $error("bad line end");
	// colour index in range
	a_fg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fg_index <= 5'd16) else $error("fg out of range");
endmodule

bind ansi_escape_attribute_parser aeap_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
	.fg_index(fg_index), .glyph(glyph)
);
